>>> design/picm_pkg.sv
// Package with constants, types and state codes of the pixel implant correlation map.
`timescale 1ns / 1ps
package picm_pkg;
  localparam int GRID_SIZE  = 40;
  localparam int TIME_WIDTH = 48;
  localparam int CELLS      = GRID_SIZE * GRID_SIZE;
  localparam int ADDR_W     = $clog2(CELLS);
  localparam int POS_W      = 6;
  localparam int RAD_W      = 2;
  localparam int WR_W       = 11;
  localparam int NB_W       = 6;
  localparam int ENTRY_W    = TIME_WIDTH + 1;
  localparam logic [TIME_WIDTH-1:0] TIMEOUT_RESET = TIME_WIDTH'(64'd1000000000);
  localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(1);

  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_RADIUS  = 1'b1;

  localparam logic OP_IMPLANT = 1'b0;
  localparam logic OP_FLUSH   = 1'b1;

  typedef enum logic [1:0] {
    OUT_STORED  = 2'd0,
    OUT_B2B     = 2'd1,
    OUT_BLOCKED = 2'd2,
    OUT_FLUSH   = 2'd3
  } outcome_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXPIRE,
    ST_NEAR,
    ST_DECIDE,
    ST_MOVE,
    ST_FLUSH,
    ST_FINAL
  } state_t;

  typedef struct packed {
    logic                  valid;
    logic [TIME_WIDTH-1:0] tstamp;
  } entry_t;
endpackage

>>> design/picm_ram.sv
// Generic one-write one-read RAM with registered read data.
`timescale 1ns / 1ps
module picm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> design/pixel_implant_correlation_map.sv
// Top level of the pixel implant correlation map with its scan sequencer.
// After reset a clearing pass over all 1600 cells empties both maps; no item is taken then.
// An implant event scans all cells for expiry, then its neighbourhood of 1 to 49 cells, and
// scans that neighbourhood again when pixels move; a flush scans all cells once.
// One item is in work at a time; the next can be taken in the cycle after a result is latched.
// Reset is synchronous and active low; configuration returns to its reset values.
`timescale 1ns / 1ps
module pixel_implant_correlation_map (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // pixel_row[5:0], pixel_col[11:6], event_time[59:12]
  input  logic        in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // expired_written[10:0], back_to_back_count[16:11]
  output logic [1:0]  out_tuser,  // outcome
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [47:0] cfg_wdata
);
  import picm_pkg::*;

  state_t state_r, state_nxt;

  logic [TIME_WIDTH-1:0] timeout_r;
  logic [RAD_W-1:0]      radius_r;
  logic [TIME_WIDTH-1:0] now_r;
  logic [POS_W-1:0]      rlo_r, rhi_r, clo_r, chi_r, a_r, b_r;
  logic [ADDR_W-1:0]     self_r, idx_r, pend_addr_r;
  logic                  pend_r, done_r;
  logic [WR_W-1:0]       wr_cnt_r;
  logic [NB_W-1:0]       icnt_r;
  logic                  bnz_r;
  outcome_t              outcome_r;
  logic                  out_valid_r;
  logic [1:0]            out_kind_r;
  logic [WR_W-1:0]       out_wr_r;
  logic [NB_W-1:0]       out_nb_r;

  logic [POS_W-1:0] in_row, in_col, row_c, col_c;
  logic [POS_W:0]   row_hi, col_hi;
  logic [ADDR_W-1:0] nb_addr, raddr;
  logic              iwe, bwe;
  logic [ADDR_W-1:0] iwaddr, bwaddr;
  entry_t            iwdata, bwdata, qi, qb;
  logic              exp_i, exp_b;
  logic [TIME_WIDTH:0] di, db;
  logic              issue, last_issue, scan_nb, accept;

  assign in_row = in_tdata[5:0];
  assign in_col = in_tdata[11:6];
  assign row_c  = (in_row >= POS_W'(GRID_SIZE)) ? POS_W'(GRID_SIZE - 1) : in_row;
  assign col_c  = (in_col >= POS_W'(GRID_SIZE)) ? POS_W'(GRID_SIZE - 1) : in_col;
  assign row_hi = {1'b0, row_c} + {{(POS_W-RAD_W+1){1'b0}}, radius_r};
  assign col_hi = {1'b0, col_c} + {{(POS_W-RAD_W+1){1'b0}}, radius_r};
  assign accept = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);

  assign nb_addr = ADDR_W'(a_r) * ADDR_W'(GRID_SIZE) + ADDR_W'(b_r);
  assign scan_nb = (state_r == ST_NEAR) || (state_r == ST_MOVE);
  assign raddr   = scan_nb ? nb_addr : idx_r;
  assign issue   = !done_r && ((state_r == ST_EXPIRE) || (state_r == ST_FLUSH) || scan_nb);
  assign last_issue = scan_nb ? ((a_r == rhi_r) && (b_r == chi_r))
                              : (idx_r == ADDR_W'(CELLS - 1));

  assign di = {1'b0, now_r} - {1'b0, qi.tstamp};
  assign db = {1'b0, now_r} - {1'b0, qb.tstamp};
  assign exp_i = pend_r && qi.valid && !di[TIME_WIDTH] && (di[TIME_WIDTH-1:0] != '0)
                 && (di[TIME_WIDTH-1:0] > timeout_r);
  assign exp_b = pend_r && qb.valid && !db[TIME_WIDTH] && (db[TIME_WIDTH-1:0] != '0)
                 && (db[TIME_WIDTH-1:0] > timeout_r);

  picm_ram #(.WIDTH(ENTRY_W), .DEPTH(CELLS)) u_implant (
    .clk(clk), .we(iwe), .waddr(iwaddr), .wdata(iwdata), .raddr(raddr), .rdata(qi)
  );
  picm_ram #(.WIDTH(ENTRY_W), .DEPTH(CELLS)) u_blocked (
    .clk(clk), .we(bwe), .waddr(bwaddr), .wdata(bwdata), .raddr(raddr), .rdata(qb)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    iwe = 1'b0;
    bwe = 1'b0;
    iwaddr = pend_addr_r;
    bwaddr = pend_addr_r;
    iwdata = '{valid: 1'b0, tstamp: qi.tstamp};
    bwdata = '{valid: 1'b0, tstamp: qb.tstamp};
    unique case (state_r)
      ST_CLEAR: begin
        iwe = 1'b1;
        bwe = 1'b1;
        iwaddr = idx_r;
        bwaddr = idx_r;
        iwdata = '0;
        bwdata = '0;
        if (idx_r == ADDR_W'(CELLS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_tuser == OP_FLUSH) ? ST_FLUSH : ST_EXPIRE;
        end
      end
      ST_EXPIRE: begin
        iwe = exp_i;
        bwe = exp_b;
        if (done_r) begin
          state_nxt = ST_NEAR;
        end
      end
      ST_NEAR: begin
        if (done_r) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        iwaddr = self_r;
        bwaddr = self_r;
        iwdata = '{valid: 1'b1, tstamp: now_r};
        bwdata = '{valid: 1'b1, tstamp: now_r};
        if (bnz_r) begin
          bwe = 1'b1;
          state_nxt = ST_FINAL;
        end else if (icnt_r != '0) begin
          state_nxt = ST_MOVE;
        end else begin
          iwe = 1'b1;
          state_nxt = ST_FINAL;
        end
      end
      ST_MOVE: begin
        if (pend_r && (pend_addr_r == self_r)) begin
          iwe = 1'b1;
          bwe = 1'b1;
          bwdata = '{valid: 1'b1, tstamp: now_r};
        end else if (pend_r && qi.valid) begin
          iwe = 1'b1;
          bwe = 1'b1;
          bwdata = '{valid: 1'b1, tstamp: qi.tstamp};
        end
        if (done_r) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FLUSH: begin
        iwe = pend_r && qi.valid;
        if (done_r) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= TIMEOUT_RESET;
      radius_r    <= RADIUS_RESET;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_TIMEOUT) begin
          timeout_r <= cfg_wdata[TIME_WIDTH-1:0];
        end else begin
          radius_r <= cfg_wdata[RAD_W-1:0];
        end
      end
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      pend_r      <= issue;
      pend_addr_r <= raddr;
      if (issue) begin
        if (last_issue) begin
          done_r <= 1'b1;
        end
        if (scan_nb) begin
          if (b_r == chi_r) begin
            b_r <= clo_r;
            a_r <= a_r + 1'b1;
          end else begin
            b_r <= b_r + 1'b1;
          end
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
      if (state_r != state_nxt) begin
        done_r <= 1'b0;
        a_r    <= rlo_r;
        b_r    <= clo_r;
        idx_r  <= '0;
      end
      if (iwe && (state_r == ST_EXPIRE || state_r == ST_FLUSH)) begin
        wr_cnt_r <= wr_cnt_r + 1'b1;
      end
      if (state_r == ST_NEAR && pend_r) begin
        bnz_r  <= bnz_r | qb.valid;
        icnt_r <= icnt_r + NB_W'(qi.valid);
      end
      unique case (state_r)
        ST_CLEAR: begin
          if (idx_r != ADDR_W'(CELLS - 1)) begin
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_IDLE: begin
          now_r    <= in_tdata[12 +: TIME_WIDTH];
          rlo_r    <= (row_c < POS_W'(radius_r)) ? '0 : row_c - POS_W'(radius_r);
          clo_r    <= (col_c < POS_W'(radius_r)) ? '0 : col_c - POS_W'(radius_r);
          rhi_r    <= (row_hi > (POS_W+1)'(GRID_SIZE - 1)) ? POS_W'(GRID_SIZE - 1)
                                                           : row_hi[POS_W-1:0];
          chi_r    <= (col_hi > (POS_W+1)'(GRID_SIZE - 1)) ? POS_W'(GRID_SIZE - 1)
                                                           : col_hi[POS_W-1:0];
          self_r   <= ADDR_W'(row_c) * ADDR_W'(GRID_SIZE) + ADDR_W'(col_c);
          wr_cnt_r <= '0;
          icnt_r   <= '0;
          bnz_r    <= 1'b0;
          outcome_r <= (in_tuser == OP_FLUSH) ? OUT_FLUSH : OUT_STORED;
        end
        ST_DECIDE: begin
          if (bnz_r) begin
            outcome_r <= OUT_BLOCKED;
          end else if (icnt_r != '0) begin
            outcome_r <= OUT_B2B;
          end
        end
        ST_FINAL: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= outcome_r;
            out_wr_r    <= wr_cnt_r;
            out_nb_r    <= (outcome_r == OUT_B2B) ? icnt_r + 1'b1 : '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {7'd0, out_nb_r, out_wr_r};
endmodule

>>> design/picm_checker.sv
// Port-level checker for the pixel implant correlation map and its bind.
`timescale 1ns / 1ps
module picm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import picm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("Result changed while stalled.");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("Input taken while an item is in work.");

  a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != OUT_B2B) |-> out_tdata[16:11] == 6'd0)
    else $error("Neighbour count set on a result that is not back to back.");

  a_count_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == OUT_B2B) |-> out_tdata[16:11] >= 6'd2)
    else $error("Back to back result with too small a count.");
endmodule

bind pixel_implant_correlation_map picm_checker u_picm_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);
